FILE: rtl/core/swdv_pkg.sv
// ----------------------------------------------------------------------------
// swdv_pkg
// Shared types, codes and constants of the sliding window direction vote.
// ----------------------------------------------------------------------------
package swdv_pkg;

    localparam int WINDOW_DEPTH_DEF = 16;

    localparam int TIME_W     = 32;
    localparam int SPEED_W    = 16;
    localparam int MAG_W      = 17;
    localparam int DIR_W      = 2;
    localparam int CONF_W     = 10;
    localparam int HELD_W     = 5;
    localparam int QUOT_BITS  = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // direction codes
    localparam logic [DIR_W-1:0] DIR_STOP = 2'd0;
    localparam logic [DIR_W-1:0] DIR_UP   = 2'd1;
    localparam logic [DIR_W-1:0] DIR_DOWN = 2'd2;

    localparam logic [CONF_W-1:0] CONF_FULL = 10'd1000;
    localparam logic [CONF_W-1:0] CONF_TIE  = 10'd500;

    // register reset values
    localparam logic [15:0] EXPIRY_RST  = 16'd1000;
    localparam logic [4:0]  WLIMIT_RST  = 5'd10;
    localparam logic [4:0]  MINHIST_RST = 5'd3;
    localparam logic [14:0] FAST_RST    = 15'd500;
    localparam logic [9:0]  BOOST_RST   = 10'd200;
    localparam logic [9:0]  PRELOAD_RST = 10'd700;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_EXPIRY  = 3'd0,
        CFG_WLIMIT  = 3'd1,
        CFG_MINHIST = 3'd2,
        CFG_FAST    = 3'd3,
        CFG_BOOST   = 3'd4,
        CFG_PRELOAD = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic [TIME_W-1:0]  stamp;
        logic [SPEED_W-1:0] speed;
        logic [DIR_W-1:0]   dir;
    } entry_t;

    typedef struct packed {
        logic [DIR_W-1:0]  pred;
        logic [CONF_W-1:0] conf;
    } vote_res_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXPIRE,
        S_LIMIT,
        S_VOTE,
        S_HOLD
    } ctl_state_t;

    typedef enum logic [1:0] {
        V_IDLE,
        V_DIV,
        V_FIN
    } vote_state_t;

    // absolute value of a two's complement speed, -32768 gives 32768
    function automatic logic [MAG_W-1:0] magnitude(input logic [SPEED_W-1:0] raw);
        logic [MAG_W-1:0] ext;
        ext = {1'b0, raw};
        if (raw[SPEED_W-1])
        begin
            return 17'h10000 - ext;
        end
        return ext;
    endfunction

endpackage

FILE: rtl/core/swdv_if.sv
// ----------------------------------------------------------------------------
// swdv interfaces
// Valid/ready channels for motion events, vote results and register writes.
// ----------------------------------------------------------------------------
interface swdv_evt_if import swdv_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic        [TIME_W-1:0]  time_ms;
    logic signed [SPEED_W-1:0] velocity;
    logic        [DIR_W-1:0]   direction;

    modport source (output valid, time_ms, velocity, direction, input ready);
    modport sink   (input valid, time_ms, velocity, direction, output ready);
endinterface

interface swdv_res_if import swdv_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [DIR_W-1:0]  predicted;
    logic [CONF_W-1:0] confidence_permille;
    logic              preload_up;
    logic              preload_down;
    logic [HELD_W-1:0] held_events;

    modport source (output valid, predicted, confidence_permille, preload_up,
                    preload_down, held_events, input ready);
    modport sink   (input valid, predicted, confidence_permille, preload_up,
                    preload_down, held_events, output ready);
endinterface

interface swdv_cfg_if import swdv_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/core/sliding_window_direction_vote_top.sv
// ----------------------------------------------------------------------------
// sliding_window_direction_vote_top
// Event window as a shifting row of cells, expiry and limit drops, vote unit.
// After an accept, expired entries drop first, then over-limit entries, then
// the vote runs; the divide is skipped on a tie or with too few events.
// One event in work at a time; next accept once the result is registered.
// The drop loop retires one entry a cycle, the divide one quotient bit a cycle.
// Reset (async, active low) empties the window and restores register defaults.
// ----------------------------------------------------------------------------
module sliding_window_direction_vote_top import swdv_pkg::*;
#(
    parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    swdv_evt_if.sink    evt,
    swdv_res_if.source  res,
    swdv_cfg_if.sink    cfg
);

    localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W = MAG_W + CNT_W;
    localparam int CMP_W = CNT_W + 5;

    ctl_state_t state_reg, state_next;
    logic [CNT_W-1:0]  held_reg, held_next;
    logic [CNT_W-1:0]  up_reg, up_next;
    logic [CNT_W-1:0]  down_reg, down_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [TIME_W-1:0] now_reg, now_next;

    logic [15:0] expiry_reg;
    logic [4:0]  wlimit_reg;
    logic [4:0]  minhist_reg;
    logic [14:0] fast_reg;
    logic [9:0]  boost_reg;
    logic [9:0]  preload_reg;

    logic              out_valid_reg, out_valid_next;
    logic [DIR_W-1:0]  out_pred_reg, out_pred_next;
    logic [CONF_W-1:0] out_conf_reg, out_conf_next;
    logic              out_pup_reg, out_pup_next;
    logic              out_pdn_reg, out_pdn_next;
    logic [HELD_W-1:0] out_held_reg, out_held_next;

    entry_t cell_data [WINDOW_DEPTH];
    entry_t new_entry;
    entry_t head;

    logic              accept;
    logic              full;
    logic [TIME_W-1:0] age;
    logic              expired;
    logic [CNT_W-1:0]  limit;
    logic              over;
    logic              drop_fire;
    logic              drop_now;
    logic              shift;
    logic [MAG_W-1:0]  head_mag;
    logic              vote_start;
    logic              vote_done;
    vote_res_t         vote_res;
    logic              out_free;

    assign accept = evt.valid && evt.ready;
    assign full   = (held_reg == CNT_W'(WINDOW_DEPTH));
    assign head   = cell_data[0];

    assign new_entry.stamp = evt.time_ms;
    assign new_entry.speed = evt.velocity;
    assign new_entry.dir   = evt.direction;

    // window row: entry 0 is the oldest, a drop moves every entry one place down
    for (genvar i = 0; i < WINDOW_DEPTH; i++)
    begin : g_cell
        entry_t nb;
        logic   load;
        if (i == WINDOW_DEPTH - 1)
        begin : g_last
            assign nb = new_entry;
        end
        else
        begin : g_mid
            assign nb = cell_data[i+1];
        end
        assign load = accept && !full && (held_reg == CNT_W'(i));

        swdv_cell u_cell
        (
            .clk       (clk),
            .load      (load),
            .shift     (shift),
            .load_data (new_entry),
            .nb_data   (nb),
            .data      (cell_data[i])
        );
    end

    always_comb
    begin
        age     = now_reg - head.stamp;
        expired = (held_reg != '0) && (age > {16'b0, expiry_reg});
        limit   = (CMP_W'(wlimit_reg) > CMP_W'(WINDOW_DEPTH)) ? CNT_W'(WINDOW_DEPTH)
                                                             : CNT_W'(wlimit_reg);
        over    = held_reg > limit;
        head_mag = magnitude(head.speed);
        out_free = !out_valid_reg || res.ready;

        state_next = state_reg;
        drop_fire  = 1'b0;
        vote_start = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXPIRE;
                end
            end
            S_EXPIRE:
            begin
                if (expired)
                begin
                    drop_fire = 1'b1;
                end
                else
                begin
                    state_next = S_LIMIT;
                end
            end
            S_LIMIT:
            begin
                if (over)
                begin
                    drop_fire = 1'b1;
                end
                else
                begin
                    vote_start = 1'b1;
                    state_next = S_VOTE;
                end
            end
            S_VOTE:
            begin
                if (vote_done)
                begin
                    state_next = S_HOLD;
                end
            end
            S_HOLD:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // a full window makes room for the new event on the accept beat
        drop_now = drop_fire || (accept && full);
        shift    = drop_now;

        held_next = held_reg - {{(CNT_W-1){1'b0}}, drop_now}
                             + {{(CNT_W-1){1'b0}}, accept};
        up_next   = up_reg
                    - {{(CNT_W-1){1'b0}}, drop_now && (head.dir == DIR_UP)}
                    + {{(CNT_W-1){1'b0}}, accept && (evt.direction == DIR_UP)};
        down_next = down_reg
                    - {{(CNT_W-1){1'b0}}, drop_now && (head.dir == DIR_DOWN)}
                    + {{(CNT_W-1){1'b0}}, accept && (evt.direction == DIR_DOWN)};
        sum_next  = sum_reg
                    - (drop_now ? SUM_W'(head_mag) : '0)
                    + (accept ? SUM_W'(magnitude(evt.velocity)) : '0);
        now_next  = accept ? evt.time_ms : now_reg;

        out_valid_next = out_valid_reg;
        out_pred_next  = out_pred_reg;
        out_conf_next  = out_conf_reg;
        out_pup_next   = out_pup_reg;
        out_pdn_next   = out_pdn_reg;
        out_held_next  = out_held_reg;
        if (res.valid && res.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (state_reg == S_HOLD && out_free)
        begin
            out_valid_next = 1'b1;
            out_pred_next  = vote_res.pred;
            out_conf_next  = vote_res.conf;
            out_pup_next   = (vote_res.conf > preload_reg) && (vote_res.pred == DIR_UP);
            out_pdn_next   = (vote_res.conf > preload_reg) && (vote_res.pred == DIR_DOWN);
            out_held_next  = HELD_W'(held_reg);
        end
    end

    swdv_vote #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_vote
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (vote_start),
        .held         (held_reg),
        .up_cnt       (up_reg),
        .down_cnt     (down_reg),
        .speed_sum    (sum_reg),
        .min_history  (minhist_reg),
        .fast_speed   (fast_reg),
        .boost_amount (boost_reg),
        .done         (vote_done),
        .res          (vote_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            held_reg      <= '0;
            up_reg        <= '0;
            down_reg      <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            held_reg      <= held_next;
            up_reg        <= up_next;
            down_reg      <= down_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        now_reg      <= now_next;
        out_pred_reg <= out_pred_next;
        out_conf_reg <= out_conf_next;
        out_pup_reg  <= out_pup_next;
        out_pdn_reg  <= out_pdn_next;
        out_held_reg <= out_held_next;
    end

    // register file, writes always taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expiry_reg  <= EXPIRY_RST;
            wlimit_reg  <= WLIMIT_RST;
            minhist_reg <= MINHIST_RST;
            fast_reg    <= FAST_RST;
            boost_reg   <= BOOST_RST;
            preload_reg <= PRELOAD_RST;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                CFG_EXPIRY:  expiry_reg  <= cfg.data;
                CFG_WLIMIT:  wlimit_reg  <= cfg.data[4:0];
                CFG_MINHIST: minhist_reg <= cfg.data[4:0];
                CFG_FAST:    fast_reg    <= cfg.data[14:0];
                CFG_BOOST:   boost_reg   <= cfg.data[9:0];
                CFG_PRELOAD: preload_reg <= cfg.data[9:0];
                default:     ;
            endcase
        end
    end

    assign evt.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;

    assign res.valid               = out_valid_reg;
    assign res.predicted           = out_pred_reg;
    assign res.confidence_permille = out_conf_reg;
    assign res.preload_up          = out_pup_reg;
    assign res.preload_down        = out_pdn_reg;
    assign res.held_events         = out_held_reg;

endmodule

FILE: rtl/core/swdv_cell.sv
// ----------------------------------------------------------------------------
// swdv_cell
// One window entry; loads a new event or takes its newer neighbor on a drop.
// ----------------------------------------------------------------------------
module swdv_cell import swdv_pkg::*;
(
    input  logic   clk,
    input  logic   load,
    input  logic   shift,
    input  entry_t load_data,
    input  entry_t nb_data,
    output entry_t data
);

    entry_t data_reg;
    entry_t data_next;

    always_comb
    begin
        data_next = data_reg;
        if (load)
        begin
            data_next = load_data;
        end
        else if (shift)
        begin
            data_next = nb_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

FILE: rtl/core/swdv_vote.sv
// ----------------------------------------------------------------------------
// swdv_vote
// Majority vote, restoring per-mille divide one quotient bit a cycle, boost.
// ----------------------------------------------------------------------------
module swdv_vote import swdv_pkg::*;
#(
    parameter  int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
    localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1),
    localparam int SUM_W        = MAG_W + CNT_W
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [CNT_W-1:0] held,
    input  logic [CNT_W-1:0] up_cnt,
    input  logic [CNT_W-1:0] down_cnt,
    input  logic [SUM_W-1:0] speed_sum,
    input  logic [4:0]       min_history,
    input  logic [14:0]      fast_speed,
    input  logic [9:0]       boost_amount,
    output logic             done,
    output vote_res_t        res
);

    localparam int DV_W  = CNT_W + QUOT_BITS;
    localparam int BIT_W = $clog2(QUOT_BITS);
    localparam int CMP_W = CNT_W + 5;

    vote_state_t vstate_reg, vstate_next;
    logic [DV_W-1:0]      rem_reg, rem_next;
    logic [DV_W-1:0]      dsh_reg, dsh_next;
    logic [QUOT_BITS-1:0] quot_reg, quot_next;
    logic [BIT_W-1:0]     cnt_reg, cnt_next;
    logic                 boost_reg, boost_next;
    logic [DIR_W-1:0]     pred_reg, pred_next;
    vote_res_t            res_reg, res_next;

    logic             too_few;
    logic [CNT_W-1:0] winner;
    logic [SUM_W-1:0] thresh;
    logic             ge;
    logic [CONF_W:0]  conf_sum;

    always_comb
    begin
        too_few = (held == '0) || (CMP_W'(held) < CMP_W'(min_history));
        winner  = (up_cnt > down_cnt) ? up_cnt : down_cnt;
        thresh  = SUM_W'(fast_speed) * SUM_W'(held);
        ge      = rem_reg >= dsh_reg;
        conf_sum = {1'b0, quot_reg} + (boost_reg ? {1'b0, boost_amount} : '0);

        vstate_next = vstate_reg;
        rem_next    = rem_reg;
        dsh_next    = dsh_reg;
        quot_next   = quot_reg;
        cnt_next    = cnt_reg;
        boost_next  = boost_reg;
        pred_next   = pred_reg;
        res_next    = res_reg;

        case (vstate_reg)
            V_IDLE:
            begin
                if (start)
                begin
                    boost_next = !too_few && (speed_sum > thresh);
                    rem_next   = DV_W'(winner) * DV_W'(CONF_FULL);
                    dsh_next   = {held, {(QUOT_BITS-1){1'b0}}, 1'b0} >> 1;
                    cnt_next   = BIT_W'(QUOT_BITS - 1);
                    if (too_few)
                    begin
                        pred_next   = DIR_STOP;
                        quot_next   = '0;
                        vstate_next = V_FIN;
                    end
                    else if (up_cnt == down_cnt)
                    begin
                        pred_next   = DIR_STOP;
                        quot_next   = CONF_TIE;
                        vstate_next = V_FIN;
                    end
                    else
                    begin
                        pred_next   = (up_cnt > down_cnt) ? DIR_UP : DIR_DOWN;
                        quot_next   = '0;
                        vstate_next = V_DIV;
                    end
                end
            end
            V_DIV:
            begin
                if (ge)
                begin
                    rem_next = rem_reg - dsh_reg;
                end
                dsh_next  = dsh_reg >> 1;
                quot_next = {quot_reg[QUOT_BITS-2:0], ge};
                if (cnt_reg == '0)
                begin
                    vstate_next = V_FIN;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            V_FIN:
            begin
                res_next.pred = pred_reg;
                res_next.conf = (conf_sum > {1'b0, CONF_FULL}) ? CONF_FULL
                                                               : conf_sum[CONF_W-1:0];
                vstate_next   = V_IDLE;
            end
            default:
            begin
                vstate_next = V_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vstate_reg <= V_IDLE;
        end
        else
        begin
            vstate_reg <= vstate_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg   <= rem_next;
        dsh_reg   <= dsh_next;
        quot_reg  <= quot_next;
        cnt_reg   <= cnt_next;
        boost_reg <= boost_next;
        pred_reg  <= pred_next;
        res_reg   <= res_next;
    end

    assign done = (vstate_reg == V_FIN);
    assign res  = res_reg;

endmodule

FILE: rtl/core/swdv_checker.sv
// ----------------------------------------------------------------------------
// swdv_checker
// Port-level checks of the direction vote block, bound to the top level.
// ----------------------------------------------------------------------------
module swdv_checker import swdv_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              evt_valid,
    input logic              evt_ready,
    input logic              res_valid,
    input logic              res_ready,
    input logic [DIR_W-1:0]  predicted,
    input logic [CONF_W-1:0] confidence_permille,
    input logic              preload_up,
    input logic              preload_down,
    input logic [HELD_W-1:0] held_events
);

    logic [1:0] pend_reg;
    logic [1:0] pend_next;

    // events accepted whose result beat has not gone out yet
    always_comb
    begin
        pend_next = pend_reg + {1'b0, evt_valid && evt_ready}
                             - {1'b0, res_valid && res_ready};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid && evt_ready |=> !evt_ready)
        else $error("event accepted while previous one still in work");

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid &&
            $stable({predicted, confidence_permille, preload_up, preload_down,
                     held_events}))
        else $error("stalled result beat changed");

    a_res_has_event: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> pend_reg != 2'd0)
        else $error("result beat without an accepted event");

    a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg != 2'd3)
        else $error("more than two events outstanding");

endmodule

bind sliding_window_direction_vote_top swdv_checker u_swdv_checker
(
    .clk                 (clk),
    .rst_n               (rst_n),
    .evt_valid           (evt.valid),
    .evt_ready           (evt.ready),
    .res_valid           (res.valid),
    .res_ready           (res.ready),
    .predicted           (res.predicted),
    .confidence_permille (res.confidence_permille),
    .preload_up          (res.preload_up),
    .preload_down        (res.preload_down),
    .held_events         (res.held_events)
);

FILE: verif/sliding_window_direction_vote_top_tb.sv
// ----------------------------------------------------------------------------
// sliding_window_direction_vote_top_tb
// Drives timestamped motion events into the direction vote block and compares
// every result beat with an in-bench model of the window, the expiry and limit
// drops, the majority vote, the speed boost and the preload flags. The run
// starts with hand-picked events, steps through register extremes, sweeps
// random settings and ends with a stream without stalls.
// ----------------------------------------------------------------------------
module sliding_window_direction_vote_top_tb;
    import swdv_pkg::*;

    localparam int RING_DEPTH = WINDOW_DEPTH_DEF;
    localparam int IDLE_LIMIT = 2000;
    localparam int TAIL_CYCLES = 64;
    localparam int PRINT_CAP = 40;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd7;

    typedef struct {
        logic [DIR_W-1:0]  pred;
        logic [CONF_W-1:0] conf;
        logic              up;
        logic              down;
        logic [HELD_W-1:0] held;
    } vote_expect_t;

    logic clk;
    logic rst_n;

    swdv_evt_if evt_bus ();
    swdv_res_if res_bus ();
    swdv_cfg_if cfg_bus ();

    sliding_window_direction_vote_top #(
        .WINDOW_DEPTH (RING_DEPTH)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .evt   (evt_bus),
        .res   (res_bus),
        .cfg   (cfg_bus)
    );

    // model of the window
    logic [TIME_W-1:0]  win_stamp [RING_DEPTH];
    logic [SPEED_W-1:0] win_speed [RING_DEPTH];
    logic [DIR_W-1:0]   win_dir   [RING_DEPTH];
    int                 win_first = 0;
    int                 win_count = 0;
    int                 n_up = 0;
    int                 n_down = 0;
    longint             mag_sum = 0;

    // model of the registers
    logic [15:0] reg_expiry  = EXPIRY_RST;
    logic [4:0]  reg_wlimit  = WLIMIT_RST;
    logic [4:0]  reg_minhist = MINHIST_RST;
    logic [14:0] reg_fast    = FAST_RST;
    logic [9:0]  reg_boost   = BOOST_RST;
    logic [9:0]  reg_preload = PRELOAD_RST;

    vote_expect_t      pending_votes [$];
    int                fail_count = 0;
    int                quiet_cycles = 0;
    int                ready_hold = 0;
    bit                idle_on = 1'b1;
    logic [TIME_W-1:0] now_ms = '0;
    logic [DIR_W-1:0]  trend = DIR_UP;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic int unsigned speed_abs(logic [SPEED_W-1:0] raw);
        if (raw[SPEED_W-1])
        begin
            return 32'h10000 - raw;
        end
        return raw;
    endfunction

    function automatic void retire_oldest();
        logic [DIR_W-1:0] d;
        d = win_dir[win_first];
        if (d == DIR_UP && n_up > 0)
        begin
            n_up--;
        end
        else if (d == DIR_DOWN && n_down > 0)
        begin
            n_down--;
        end
        mag_sum -= speed_abs(win_speed[win_first]);
        win_first = (win_first + 1) % RING_DEPTH;
        win_count--;
    endfunction

    function automatic vote_expect_t vote_on_event(logic [TIME_W-1:0] t,
                                                   logic [SPEED_W-1:0] v,
                                                   logic [DIR_W-1:0] d);
        int           slot;
        int           limit;
        int unsigned  winner;
        int unsigned  conf;
        logic [1:0]   pred;
        vote_expect_t e;
        winner = 0;
        conf = 0;
        pred = DIR_STOP;
        if (win_count >= RING_DEPTH)
        begin
            retire_oldest();
        end
        slot = (win_first + win_count) % RING_DEPTH;
        win_stamp[slot] = t;
        win_speed[slot] = v;
        win_dir[slot] = d;
        win_count++;
        if (d == DIR_UP)
        begin
            n_up++;
        end
        else if (d == DIR_DOWN)
        begin
            n_down++;
        end
        mag_sum += speed_abs(v);
        // ages wrap at 32 bits; stop at the first entry still young enough
        while (win_count > 0 && 32'(t - win_stamp[win_first]) > {16'd0, reg_expiry})
        begin
            retire_oldest();
        end
        limit = (reg_wlimit > RING_DEPTH) ? RING_DEPTH : int'(reg_wlimit);
        while (win_count > limit)
        begin
            retire_oldest();
        end
        if (win_count > 0 && win_count >= int'(reg_minhist))
        begin
            if (n_up > n_down)
            begin
                pred = DIR_UP;
                winner = n_up;
            end
            else if (n_down > n_up)
            begin
                pred = DIR_DOWN;
                winner = n_down;
            end
            conf = (pred != DIR_STOP) ? (winner * 1000) / win_count : 32'(CONF_TIE);
            if (mag_sum > longint'(reg_fast) * win_count)
            begin
                conf += reg_boost;
                if (conf > CONF_FULL)
                begin
                    conf = 32'(CONF_FULL);
                end
            end
        end
        e.pred = pred;
        e.conf = conf[CONF_W-1:0];
        e.up = (conf > reg_preload) && (pred == DIR_UP);
        e.down = (conf > reg_preload) && (pred == DIR_DOWN);
        e.held = win_count[HELD_W-1:0];
        return e;
    endfunction

    task automatic report_mismatch(string msg);
        fail_count++;
        if (fail_count <= PRINT_CAP)
        begin
            $display("%0t: %s", $time, msg);
        end
    endtask

    task automatic check_field(string name, int got, int want);
        if (got != want)
        begin
            report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
        end
    endtask

    // register beats update the model
    always @(posedge clk)
    begin
        if (cfg_bus.valid && cfg_bus.ready)
        begin
            case (cfg_bus.index)
                CFG_EXPIRY:  reg_expiry  = cfg_bus.data[15:0];
                CFG_WLIMIT:  reg_wlimit  = cfg_bus.data[4:0];
                CFG_MINHIST: reg_minhist = cfg_bus.data[4:0];
                CFG_FAST:    reg_fast    = cfg_bus.data[14:0];
                CFG_BOOST:   reg_boost   = cfg_bus.data[9:0];
                CFG_PRELOAD: reg_preload = cfg_bus.data[9:0];
                default:     ;
            endcase
        end
    end

    // event beats feed the model
    always @(posedge clk)
    begin
        if (evt_bus.valid && evt_bus.ready)
        begin
            pending_votes.insert(pending_votes.size(),
                                 vote_on_event(evt_bus.time_ms, evt_bus.velocity,
                                               evt_bus.direction));
        end
    end

    // result beats against the oldest expectation
    always @(posedge clk)
    begin : check_beat
        vote_expect_t e;
        if (res_bus.valid && res_bus.ready)
        begin
            if (pending_votes.size() == 0)
            begin
                report_mismatch("result beat with nothing expected");
            end
            else
            begin
                e = pending_votes[0];
                pending_votes.delete(0);
                check_field("predicted", res_bus.predicted, e.pred);
                check_field("confidence_permille", res_bus.confidence_permille, e.conf);
                check_field("preload_up", res_bus.preload_up, e.up);
                check_field("preload_down", res_bus.preload_down, e.down);
                check_field("held_events", res_bus.held_events, e.held);
            end
        end
    end

    // receiver stalls in bursts, which start only while idle_on is set
    always @(posedge clk)
    begin
        if (ready_hold > 0)
        begin
            ready_hold--;
            res_bus.ready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 5) == 0)
        begin
            ready_hold = $urandom_range(0, 16);
            res_bus.ready <= 1'b0;
        end
        else
        begin
            res_bus.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if ((evt_bus.valid && evt_bus.ready) || (res_bus.valid && res_bus.ready) ||
            (cfg_bus.valid && cfg_bus.ready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= IDLE_LIMIT)
            begin
                $display("sliding_window_direction_vote_top_tb: done, errors");
                $finish;
            end
        end
    end

    // valid stays high across back-to-back beats
    task automatic send_event(logic [TIME_W-1:0] t, logic [SPEED_W-1:0] v,
                              logic [DIR_W-1:0] d);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            evt_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        evt_bus.valid <= 1'b1;
        evt_bus.time_ms <= t;
        evt_bus.velocity <= v;
        evt_bus.direction <= d;
        do
            @(posedge clk);
        while (!(evt_bus.valid && evt_bus.ready));
    endtask

    task automatic wait_drain();
        evt_bus.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_votes.size() != 0);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val, int width);
        logic [15:0] junk;
        junk = '0;
        // stray bits above the register width must be dropped
        if (width < CFG_DATA_W && $urandom_range(0, 3) == 0)
        begin
            junk = 16'($urandom) << width;
        end
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data <= val[15:0] | junk;
        do
            @(posedge clk);
        while (!(cfg_bus.valid && cfg_bus.ready));
    endtask

    task automatic apply_settings(int expiry, int wlimit, int minhist, int fast,
                                  int boost, int preload, bit spare);
        wait_drain();
        write_reg(CFG_EXPIRY, expiry, 16);
        write_reg(CFG_WLIMIT, wlimit, 5);
        write_reg(CFG_MINHIST, minhist, 5);
        write_reg(CFG_FAST, fast, 15);
        write_reg(CFG_BOOST, boost, 10);
        write_reg(CFG_PRELOAD, preload, 10);
        if (spare)
        begin
            write_reg(CFG_IDX_SPARE, $urandom, CFG_DATA_W);
        end
        cfg_bus.valid <= 1'b0;
    endtask

    // mostly steady motion in one trend, with expiry jumps and noise mixed in
    task automatic send_motion(int count);
        int r;
        int mag;
        logic [SPEED_W-1:0] v;
        logic [DIR_W-1:0] d;
        repeat (count)
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
            begin
                now_ms += $urandom_range(0, reg_expiry / 3 + 1);
            end
            else if (r < 80)
            begin
                now_ms += reg_expiry + $urandom_range(1, 2000);
            end
            else if (r < 85)
            begin
                now_ms = $urandom;
            end
            else if (r < 90)
            begin
                now_ms -= $urandom_range(1, 50);
            end
            r = $urandom_range(0, 99);
            if (r < 40)
            begin
                v = 16'($urandom);
            end
            else if (r < 85)
            begin
                mag = $urandom_range(0, 2 * reg_fast + 2);
                if (mag > 32767)
                begin
                    mag = 32767;
                end
                v = 16'($urandom_range(0, 1) ? -mag : mag);
            end
            else
            begin
                case ($urandom_range(0, 3))
                    0: v = 16'h7fff;
                    1: v = 16'h8000;
                    2: v = 16'h0000;
                    default: v = 16'hffff;
                endcase
            end
            if ($urandom_range(0, 19) == 0)
            begin
                trend = $urandom_range(0, 1) ? DIR_UP : DIR_DOWN;
            end
            r = $urandom_range(0, 99);
            if (r < 60)
            begin
                d = trend;
            end
            else if (r < 90)
            begin
                d = DIR_W'($urandom_range(0, 2));
            end
            else
            begin
                d = 2'd3;
            end
            send_event(now_ms, v, d);
        end
    endtask

    task automatic test_directed_defaults();
        send_event(32'd0, 16'd0, DIR_STOP);
        send_event(32'd10, 16'h7fff, DIR_UP);
        send_event(32'd20, 16'h8000, DIR_UP);
        send_event(32'd30, 16'hffff, DIR_DOWN);
        // code 3 is held but votes as stopped
        send_event(32'd40, 16'd100, 2'd3);
        send_event(32'd50, 16'd5, DIR_DOWN);
        send_event(32'd60, 16'd5, DIR_DOWN);
        // age across the counter wrap
        send_event(32'hffff_fff0, 16'd1, DIR_UP);
        send_event(32'h0000_0010, 16'd2, DIR_UP);
        send_event(32'h0000_0020, 16'd3, DIR_UP);
        send_event(32'h8000_0000, 16'd4, DIR_DOWN);
        // an entry stamped later than the new event wraps to a large age and expires
        send_event(32'd1000, 16'd7, DIR_DOWN);
        send_event(32'd2500, 16'd7, DIR_DOWN);
        send_event(32'd1500, 16'd7, DIR_DOWN);
        send_event(32'd1600, 16'h4000, DIR_UP);
        send_event(32'd2601, 16'hc000, DIR_UP);
        send_event(32'hffff_ffff, 16'h5555, DIR_STOP);
        send_event(32'haaaa_aaaa, 16'haaaa, DIR_UP);
        send_event(32'h5555_5555, 16'h7ffe, DIR_DOWN);
    endtask

    task automatic test_register_extremes();
        now_ms = 32'd5000;
        // limit above the ring depth, so the full ring drops its oldest
        apply_settings(65535, 31, 1, 0, 1023, 0, 1'b1);
        send_motion(24);
        apply_settings(0, 0, 16, 32767, 0, 1000, 1'b0);
        send_motion(12);
        apply_settings(0, 16, 0, 0, 1000, 1023, 1'b1);
        send_motion(16);
        apply_settings(65535, 1, 1, 32767, 1023, 999, 1'b0);
        send_motion(12);
        apply_settings(3000, 16, 31, 100, 500, 500, 1'b0);
        send_motion(20);
        apply_settings(EXPIRY_RST, WLIMIT_RST, MINHIST_RST, FAST_RST, BOOST_RST,
                       PRELOAD_RST, 1'b0);
        send_motion(20);
    endtask

    task automatic apply_random_settings();
        int expiry;
        int wlimit;
        int minhist;
        int fast;
        expiry = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 20)
               : ($urandom_range(0, 4) == 0) ? $urandom_range(0, 65535)
               : $urandom_range(50, 5000);
        wlimit = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 16);
        minhist = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 8);
        fast = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 32767) : $urandom_range(0, 3000);
        apply_settings(expiry, wlimit, minhist, fast, $urandom_range(0, 1023),
                       $urandom_range(0, 1023), 1'($urandom_range(0, 1)));
    endtask

    task automatic test_random_sweep();
        for (int phase = 0; phase < 10; phase++)
        begin
            idle_on = (phase % 3 != 2);
            apply_random_settings();
            now_ms = (phase % 4 == 0) ? 32'hffff_ff00 : $urandom;
            send_motion(30);
            // hold off until every vote is back
            wait_drain();
            send_motion(25);
        end
    endtask

    task automatic test_steady_stream();
        idle_on = 1'b0;
        apply_random_settings();
        send_motion(100);
    endtask

    initial
    begin
        rst_n <= 1'b0;
        evt_bus.valid <= 1'b0;
        evt_bus.time_ms <= '0;
        evt_bus.velocity <= '0;
        evt_bus.direction <= DIR_STOP;
        cfg_bus.valid <= 1'b0;
        cfg_bus.index <= CFG_EXPIRY;
        cfg_bus.data <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_defaults();
        test_register_extremes();
        test_random_sweep();
        test_steady_stream();
        wait_drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_votes.size() == 0 && fail_count == 0)
        begin
            $display("sliding_window_direction_vote_top_tb: done, clean");
        end
        else
        begin
            $display("sliding_window_direction_vote_top_tb: done, errors");
        end
        $finish;
    end

endmodule
